### hdl/mcr_pkg.sv
// Shared types, constants and the microcode table of the circle rasterizer.
`timescale 1ns / 1ps

package mcr_pkg;

  // Output coordinate width, fixed by the pixel word format
  localparam int PIX_W = 15;

  // Microprogram counter width
  localparam int PC_W = 4;

  // Datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_ROOT,
    OP_INIT,
    OP_EMIT
  } op_e;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_GOTO,
    JC_LOOP,
    JC_DISPATCH
  } jc_e;

  // One control word of the microprogram
  typedef struct packed {
    op_e            op;
    logic [2:0]     pix;
    jc_e            jc;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control from sequencer to datapath
  typedef struct packed {
    op_e        op;
    logic [2:0] pix;
    logic       fire;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic active;
    logic root_last;
    logic out_busy;
  } stat_t;

  // Microprogram addresses
  localparam logic [PC_W-1:0] UPC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] UPC_DIFF = 4'd1;
  localparam logic [PC_W-1:0] UPC_SQX  = 4'd2;
  localparam logic [PC_W-1:0] UPC_SQY  = 4'd3;
  localparam logic [PC_W-1:0] UPC_ROOT = 4'd4;
  localparam logic [PC_W-1:0] UPC_INIT = 4'd5;
  localparam logic [PC_W-1:0] UPC_PIX0 = 4'd6;
  localparam logic [PC_W-1:0] UPC_PIX1 = 4'd7;
  localparam logic [PC_W-1:0] UPC_PIX2 = 4'd8;
  localparam logic [PC_W-1:0] UPC_PIX3 = 4'd9;
  localparam logic [PC_W-1:0] UPC_PIX4 = 4'd10;
  localparam logic [PC_W-1:0] UPC_PIX5 = 4'd11;
  localparam logic [PC_W-1:0] UPC_PIX6 = 4'd12;
  localparam logic [PC_W-1:0] UPC_PIX7 = 4'd13;

  // Octant codes: bit 0 negates the column part, bit 1 the row part, bit 2 swaps x and y
  localparam logic [2:0] OCT_0 = 3'd0;
  localparam logic [2:0] OCT_1 = 3'd1;
  localparam logic [2:0] OCT_2 = 3'd2;
  localparam logic [2:0] OCT_3 = 3'd3;
  localparam logic [2:0] OCT_4 = 3'd4;
  localparam logic [2:0] OCT_5 = 3'd5;
  localparam logic [2:0] OCT_6 = 3'd6;
  localparam logic [2:0] OCT_7 = 3'd7;

  // Microcode ROM
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_WAIT, pix: OCT_0, jc: JC_GOTO, target: UPC_IDLE};
    unique case (pc)
      UPC_IDLE: w = '{op: OP_WAIT, pix: OCT_0, jc: JC_DISPATCH, target: UPC_DIFF};
      UPC_DIFF: w = '{op: OP_DIFF, pix: OCT_0, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_SQX:  w = '{op: OP_SQX,  pix: OCT_0, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_SQY:  w = '{op: OP_SQY,  pix: OCT_0, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_ROOT: w = '{op: OP_ROOT, pix: OCT_0, jc: JC_LOOP,     target: UPC_ROOT};
      UPC_INIT: w = '{op: OP_INIT, pix: OCT_0, jc: JC_GOTO,     target: UPC_IDLE};
      UPC_PIX0: w = '{op: OP_EMIT, pix: OCT_0, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX1: w = '{op: OP_EMIT, pix: OCT_1, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX2: w = '{op: OP_EMIT, pix: OCT_2, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX3: w = '{op: OP_EMIT, pix: OCT_3, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX4: w = '{op: OP_EMIT, pix: OCT_4, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX5: w = '{op: OP_EMIT, pix: OCT_5, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX6: w = '{op: OP_EMIT, pix: OCT_6, jc: JC_NEXT,     target: UPC_IDLE};
      UPC_PIX7: w = '{op: OP_EMIT, pix: OCT_7, jc: JC_GOTO,     target: UPC_IDLE};
      default:  w = '{op: OP_WAIT, pix: OCT_0, jc: JC_GOTO,     target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/mcr_if.sv
// Valid/ready channel interfaces for command words and pixel words.
`timescale 1ns / 1ps

interface mcr_in_if #(
  parameter int COORD_BITS = 13
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] edge_x;
  logic signed [COORD_BITS-1:0] edge_y;

  modport source (
    output valid, cmd, center_x, center_y, edge_x, edge_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, center_x, center_y, edge_x, edge_y,
    output ready
  );
endinterface

interface mcr_out_if;
  import mcr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    run_last;
  logic                    circle_done;

  modport source (
    output valid, pixel_x, pixel_y, run_last, circle_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, run_last, circle_done,
    output ready
  );
endinterface

### hdl/mcr_sequencer.sv
// Microprogram sequencer: step counter, control word fetch and jumps.
`timescale 1ns / 1ps

module mcr_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_cmd_i,
  input  mcr_pkg::stat_t  stat_i,
  output logic            in_ready_o,
  output mcr_pkg::ctrl_t  ctrl_o
);
  import mcr_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            fire;

  // Fetch the control word of the current step
  assign uw = ucode(pc_q);

  assign in_ready_o = (uw.op == OP_WAIT);

  // Hold a step until its handshake or output slot allows it
  always_comb begin
    unique case (uw.op)
      OP_WAIT: fire = in_valid_i;
      OP_EMIT: fire = !stat_i.out_busy;
      default: fire = 1'b1;
    endcase
  end

  assign ctrl_o = '{op: uw.op, pix: uw.pix, fire: fire};

  // Advance or jump
  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      unique case (uw.jc)
        JC_NEXT: pc_d = pc_q + PC_W'(1);
        JC_GOTO: pc_d = uw.target;
        JC_LOOP: pc_d = stat_i.root_last ? pc_q + PC_W'(1) : uw.target;
        JC_DISPATCH: begin
          if (!in_cmd_i) begin
            pc_d = uw.target;
          end else if (stat_i.active) begin
            pc_d = UPC_PIX0;
          end else begin
            pc_d = UPC_IDLE;
          end
        end
        default: pc_d = UPC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### hdl/mcr_datapath.sv
// Datapath: operand registers, shared squarer, root iteration, octant pixel adders.
`timescale 1ns / 1ps

module mcr_datapath #(
  parameter int COORD_BITS = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcr_pkg::ctrl_t                    ctrl_i,
  input  logic                              in_cmd_i,
  input  logic signed [COORD_BITS-1:0]      center_x_i,
  input  logic signed [COORD_BITS-1:0]      center_y_i,
  input  logic signed [COORD_BITS-1:0]      edge_x_i,
  input  logic signed [COORD_BITS-1:0]      edge_y_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [mcr_pkg::PIX_W-1:0]  pixel_x_o,
  output logic signed [mcr_pkg::PIX_W-1:0]  pixel_y_o,
  output logic                              run_last_o,
  output logic                              circle_done_o,
  output mcr_pkg::stat_t                    stat_o
);
  import mcr_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int SQW  = 2 * DW + 1;
  localparam int SQE  = SQW + (SQW % 2);
  localparam int HW   = SQE / 2;
  localparam int OW   = HW + 1;
  localparam int DECW = OW + 4;
  localparam int SUMW = (OW + 1 > PIX_W) ? OW + 1 : PIX_W;

  // Latched command operands
  logic signed [COORD_BITS-1:0] cx_q, cy_q, ex_q, ey_q;
  logic signed [DW-1:0]         dx_q, dy_q;

  // Root state
  logic [SQE-1:0] n_q, res_q, bit_q;

  // Circle state
  logic                  active_q;
  logic signed [OW-1:0]  x_q, y_q;
  logic signed [DECW-1:0] d_q;

  // Output register
  logic                    out_valid_q;
  logic signed [PIX_W-1:0] pixel_x_q, pixel_y_q;
  logic                    run_last_q, circle_done_q;

  logic do_op;
  assign do_op = ctrl_i.fire;

  // Shared squarer
  logic signed [DW-1:0]   mul_a;
  logic signed [2*DW-1:0] mul_p;
  logic [SQE-1:0]         sq_term;

  assign mul_a   = (ctrl_i.op == OP_SQX) ? dx_q : dy_q;
  assign mul_p   = mul_a * mul_a;
  assign sq_term = SQE'($unsigned(mul_p));

  // Root trial subtract
  logic [SQE:0] trial;
  logic         take;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = ({1'b0, n_q} >= trial);

  // Decision update
  logic signed [DECW-1:0] x_e, y_e, d_nxt;
  logic signed [OW-1:0]   x_nxt, y_nxt;
  logic                   done_nxt;

  assign x_e   = DECW'(x_q);
  assign y_e   = DECW'(y_q);
  assign x_nxt = x_q + OW'(1);

  always_comb begin
    if (!d_q[DECW-1]) begin
      d_nxt = d_q + ((x_e - y_e) <<< 2) + DECW'(10);
      y_nxt = y_q - OW'(1);
    end else begin
      d_nxt = d_q + (x_e <<< 2) + DECW'(6);
      y_nxt = y_q;
    end
  end

  assign done_nxt = (x_nxt > y_nxt);

  // Octant pixel
  logic signed [OW-1:0]   a_part, b_part;
  logic signed [SUMW-1:0] cx_e, cy_e, a_e, b_e, px, py;

  assign a_part = ctrl_i.pix[2] ? y_q : x_q;
  assign b_part = ctrl_i.pix[2] ? x_q : y_q;
  assign cx_e   = SUMW'(cx_q);
  assign cy_e   = SUMW'(cy_q);
  assign a_e    = SUMW'(a_part);
  assign b_e    = SUMW'(b_part);
  assign px     = ctrl_i.pix[0] ? cx_e - a_e : cx_e + a_e;
  assign py     = ctrl_i.pix[1] ? cy_e - b_e : cy_e + b_e;

  logic emit, emit_last;
  assign emit      = do_op && (ctrl_i.op == OP_EMIT);
  assign emit_last = emit && (ctrl_i.pix == OCT_7);

  // Operand and root registers
  always_ff @(posedge clk_i) begin
    if (do_op) begin
      unique case (ctrl_i.op)
        OP_WAIT: begin
          if (!in_cmd_i) begin
            cx_q <= center_x_i;
            cy_q <= center_y_i;
            ex_q <= edge_x_i;
            ey_q <= edge_y_i;
          end
        end
        OP_DIFF: begin
          dx_q <= DW'(ex_q) - DW'(cx_q);
          dy_q <= DW'(ey_q) - DW'(cy_q);
        end
        OP_SQX: begin
          n_q <= sq_term;
        end
        OP_SQY: begin
          n_q   <= n_q + sq_term;
          res_q <= '0;
          bit_q <= {2'b01, {(SQE-2){1'b0}}};
        end
        OP_ROOT: begin
          if (take) begin
            n_q   <= n_q - trial[SQE-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        default: ;
      endcase
    end
  end

  // Circle state: load on init, advance after the eighth pixel
  always_ff @(posedge clk_i) begin
    if (do_op && ctrl_i.op == OP_INIT) begin
      x_q <= '0;
      y_q <= OW'(res_q[HW-1:0]);
      d_q <= DECW'(3) - (DECW'(res_q[HW-1:0]) <<< 1);
    end else if (emit_last) begin
      x_q <= x_nxt;
      y_q <= y_nxt;
      d_q <= d_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (do_op && ctrl_i.op == OP_INIT) begin
      active_q <= 1'b1;
    end else if (emit_last && done_nxt) begin
      active_q <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_x_q     <= px[PIX_W-1:0];
      pixel_y_q     <= py[PIX_W-1:0];
      run_last_q    <= emit_last;
      circle_done_q <= emit_last && done_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign run_last_o    = run_last_q;
  assign circle_done_o = circle_done_q;

  assign stat_o = '{
    active:    active_q,
    root_last: bit_q[0],
    out_busy:  out_valid_q && !out_ready_i
  };

endmodule

### hdl/midpoint_circle_rasterizer.sv
// Start word: after acceptance, the setup steps (difference, x square, y square), the root loop and init.
// Step word: after acceptance, 8 pixel words follow, one per cycle while the output does not stall.
// The first pixel step loads the first pixel word into the output register; output stalls hold the
// microprogram on the pending pixel step. Start and step rates are set by the root loop and
// the single output register. Reset clears the step counter, the circle flag and output valid.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer #(
  parameter int COORD_BITS = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcr_in_if.sink    in_i,
  mcr_out_if.source out_o
);
  import mcr_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Microprogram sequencer
  mcr_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  // Datapath
  mcr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .in_cmd_i      (in_i.cmd),
    .center_x_i    (in_i.center_x),
    .center_y_i    (in_i.center_y),
    .edge_x_i      (in_i.edge_x),
    .edge_y_i      (in_i.edge_y),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .run_last_o    (out_o.run_last),
    .circle_done_o (out_o.circle_done),
    .stat_o        (stat)
  );

endmodule

### test/tb_top.sv
// Testbench for the circle rasterizer: random circle commands checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import mcr_pkg::*;

  localparam int   COORD_BITS    = 13;
  localparam int   CLK_HALF      = 5;
  localparam int   RESET_CYCLES  = 6;
  localparam int   N_WORDS       = 180;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   MAX_REPORTS   = 10;
  localparam int   MAX_WAIT      = 7;
  localparam int   C_MIN         = -(1 << (COORD_BITS - 1));
  localparam int   C_MAX         = (1 << (COORD_BITS - 1)) - 1;
  localparam logic CMD_START     = 1'b0;
  localparam logic CMD_STEP      = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             done;
  } pixel_t;

  // Circle tracker: mirrors the rasterizer state and holds the pixel words still owed
  class circle_scoreboard;
    bit          drawing;
    int          col;
    int          row;
    int          off_x;
    int          off_y;
    int          dvar;
    pixel_t      pending_pixels[$];
    int unsigned n_bad;
    int unsigned n_checked;
    int unsigned n_starts;
    int unsigned n_steps;
    int unsigned n_closed;

    function new();
      drawing   = 1'b0;
      col       = 0;
      row       = 0;
      off_x     = 0;
      off_y     = 0;
      dvar      = 0;
      n_bad     = 0;
      n_checked = 0;
      n_starts  = 0;
      n_steps   = 0;
      n_closed  = 0;
    endfunction

    // Floor of the square root by bisection; squared distance stays below 2^32
    static function int root_floor(longint sq);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= sq) lo = mid;
        else hi = mid - 1;
      end
      return int'(lo);
    endfunction

    function void push_pixel(int px, int py, bit last, bit done);
      pixel_t p;
      p.px   = px[PIX_W-1:0];
      p.py   = py[PIX_W-1:0];
      p.last = last;
      p.done = done;
      pending_pixels.push_back(p);
    endfunction

    // Advance the tracked state for one accepted command word
    function void note_word(logic cmd, coord_t cx, coord_t cy, coord_t ex, coord_t ey);
      int dx;
      int dy;
      int x;
      int y;
      bit done;
      if (cmd == CMD_START) begin
        dx      = int'(ex) - int'(cx);
        dy      = int'(ey) - int'(cy);
        col     = int'(cx);
        row     = int'(cy);
        off_x   = 0;
        off_y   = root_floor(longint'(dx) * dx + longint'(dy) * dy);
        dvar    = 3 - 2 * off_y;
        drawing = 1'b1;
        n_starts++;
      end else if (drawing) begin
        x = off_x;
        y = off_y;
        if (dvar >= 0) begin
          dvar  += 4 * (x - y) + 10;
          off_y  = y - 1;
        end else begin
          dvar += 4 * x + 6;
        end
        off_x = x + 1;
        done  = (off_x > off_y);
        if (done) begin
          drawing = 1'b0;
          n_closed++;
        end
        n_steps++;
        // Eight octant mirrors in fixed order
        push_pixel(col + x, row + y, 1'b0, 1'b0);
        push_pixel(col - x, row + y, 1'b0, 1'b0);
        push_pixel(col + x, row - y, 1'b0, 1'b0);
        push_pixel(col - x, row - y, 1'b0, 1'b0);
        push_pixel(col + y, row + x, 1'b0, 1'b0);
        push_pixel(col - y, row + x, 1'b0, 1'b0);
        push_pixel(col + y, row - x, 1'b0, 1'b0);
        push_pixel(col - y, row - x, 1'b1, done);
      end
    endfunction

    // Compare one accepted pixel word with the oldest one owed
    function void check_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic last,
                              logic done);
      pixel_t want;
      n_checked++;
      if (pending_pixels.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("pixel %0d: none owed, got (%0d,%0d) last=%0b done=%0b",
                   n_checked, $signed(px), $signed(py), last, done);
        return;
      end
      want = pending_pixels.pop_front();
      if (want.px !== px || want.py !== py || want.last !== last || want.done !== done) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display({"pixel %0d: expected (%0d,%0d) last=%0b done=%0b, ",
                    "got (%0d,%0d) last=%0b done=%0b"},
                   n_checked, $signed(want.px), $signed(want.py), want.last, want.done,
                   $signed(px), $signed(py), last, done);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mcr_in_if #(.COORD_BITS(COORD_BITS)) in_bus ();
  mcr_out_if                           out_bus ();

  midpoint_circle_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  circle_scoreboard sb;
  bit               calm;
  int unsigned      n_words;
  int unsigned      n_idle_steps;

  // Free-running clock
  always #CLK_HALF clk_i = ~clk_i;

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
  endfunction

  // Point at offset d from c, mirrored back when it would leave the field range
  function automatic coord_t near_coord(coord_t c, int d);
    int e;
    e = int'(c) + d;
    if (e > C_MAX || e < C_MIN) e = int'(c) - d;
    return coord_t'(e);
  endfunction

  // Drive one command word after a random gap and hold it until accepted
  task automatic send_word(logic cmd, coord_t cx, coord_t cy, coord_t ex, coord_t ey);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.cmd      <= cmd;
    in_bus.center_x <= cx;
    in_bus.center_y <= cy;
    in_bus.edge_x   <= ex;
    in_bus.edge_y   <= ey;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    if (cmd == CMD_STEP && !sb.drawing) n_idle_steps++;
    else n_words++;
    sb.note_word(cmd, cx, cy, ex, ey);
  endtask

  // Step word with random filler in the unused coordinate fields
  task automatic send_step();
    send_word(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Start a circle, then step it until it closes or the step budget runs out
  task automatic draw_circle(coord_t cx, coord_t cy, coord_t ex, coord_t ey, int max_steps);
    int k;
    send_word(CMD_START, cx, cy, ex, ey);
    k = 0;
    while (sb.drawing && k < max_steps) begin
      send_step();
      k++;
    end
  endtask

  // Pixel sink: random stalls per word, check each accepted word
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
      sb.check_pixel(out_bus.pixel_x, out_bus.pixel_y, out_bus.run_last, out_bus.circle_done);
    end
  end

  // Command source and end of run
  initial begin
    int     kind;
    coord_t cx;
    coord_t cy;
    sb              = new();
    calm            = 1'b0;
    n_words         = 0;
    n_idle_steps    = 0;
    rst_ni          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.cmd      <= CMD_STEP;
    in_bus.center_x <= '0;
    in_bus.center_y <= '0;
    in_bus.edge_x   <= '0;
    in_bus.edge_y   <= '0;
    out_bus.ready   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: step while idle, zero radius, extreme corners, restart mid-circle
    send_step();
    draw_circle(coord_t'(C_MIN), coord_t'(C_MIN), coord_t'(C_MIN), coord_t'(C_MIN), 4);
    send_step();
    draw_circle(coord_t'(C_MAX), coord_t'(C_MAX), coord_t'(C_MIN), coord_t'(C_MIN), 2);
    draw_circle(coord_t'(C_MIN), coord_t'(C_MAX), coord_t'(C_MAX), coord_t'(C_MIN), 2);
    calm = 1'b1;
    draw_circle(coord_t'(0), coord_t'(0), coord_t'(1), coord_t'(0), 4);
    calm = 1'b0;
    draw_circle(coord_t'(100), coord_t'(-50), coord_t'(103), coord_t'(-54), 8);
    draw_circle(coord_t'(C_MAX), coord_t'(C_MIN), coord_t'(C_MAX - 2), coord_t'(C_MIN), 8);
    send_step();

    // Random: mostly small circles run to the end, some large ones dropped early, some noise
    while (n_words < N_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        cx = rand_coord();
        cy = rand_coord();
        draw_circle(cx, cy, near_coord(cx, int'($urandom_range(0, 18)) - 9),
                    near_coord(cy, int'($urandom_range(0, 18)) - 9), 1000);
      end else if (kind < 9) begin
        draw_circle(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 3)) send_step();
      end
    end
    in_bus.valid <= 1'b0;
    calm = 1'b0;

    // Drain owed pixels, then allow for stray words
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d circle starts (%0d closed), %0d drawing steps, %0d ignored steps",
             sb.n_starts, sb.n_closed, sb.n_steps, n_idle_steps);
    $display("checked %0d pixel words, %0d wrong, %0d still owed",
             sb.n_checked, sb.n_bad, sb.pending_pixels.size());
    if (sb.n_bad == 0 && sb.pending_pixels.size() == 0) begin
      $display("midpoint_circle_rasterizer: match");
    end else begin
      $display("midpoint_circle_rasterizer: mismatch");
    end
    $finish;
  end

  // Watchdog: 3 ms is far beyond the slowest legal run
  initial begin
    #(3_000_000);
    $display("run timed out");
    $display("midpoint_circle_rasterizer: mismatch");
    $finish;
  end

endmodule
